// File: design/dtpt_pkg.sv
// ----------------------------------------------------------------------------
// dtpt_pkg
// Shared constants, state encoding and the command and status bundles of the
// distance threshold point thinning block.
// ----------------------------------------------------------------------------
package dtpt_pkg;

    localparam int MAX_POINTS_DEF = 64;
    localparam int COORD_BITS_DEF = 24;
    localparam int SCALAR_W       = 32;
    localparam int DIST_W         = 23;
    localparam logic [DIST_W-1:0] DIST_RESET = 23'd2560;

    // Configuration port: one 32-bit register per word address.
    localparam int APB_ADDR_W     = 3;
    localparam int APB_DATA_W     = 32;
    localparam logic REG_IDX_MERGE_DISTANCE = 1'b0;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_SQUARE,
        ST_PIVOT,
        ST_PIVLD,
        ST_SWEEP,
        ST_DRAIN,
        ST_FINDLAST,
        ST_EMIT
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic wr_en;        // store the accepted point
        logic start;        // capture the threshold for this set
        logic square;       // compute the squared threshold
        logic piv_load;     // latch pivot coordinates from the read data
        logic cmp_issue;    // read data of this address enters the compare pipe
        logic emit_issue;   // read data of this address goes to the output
        logic emit_final;   // the emitted point is the last survivor
        logic overflow;     // the set lost points to a full store
        logic clear;        // clear removal marks for the next set
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic removed;      // removal mark at the current read index
        logic pipe_busy;    // a compare is still in flight
        logic emit_ok;      // the output register can take the next point
        logic emit_pend;    // a read for the output is in flight
    } status_t;

endpackage

// File: design/distance_threshold_point_thinning.sv
// ----------------------------------------------------------------------------
// distance_threshold_point_thinning
// Greedy thinning of a set of 3D points by a distance threshold.
//
// Points arrive on s_axis, one beat each, with the coordinates and a 32-bit
// scalar in tdata; tlast marks the final point of a set. Up to MAX_POINTS
// points are stored; further points are dropped and the set is flagged. After
// the last beat each surviving point, in arrival order, removes every later
// point whose squared distance to it is at most merge_distance squared.
// Survivors leave on m_axis in arrival order; tlast marks the last survivor
// and tuser flags a set that overflowed. merge_distance is set over APB.
// Loading accepts one beat per cycle. Each surviving point is latched as
// pivot, every later point is swept through the compare pipe and the pipe
// is drained; removed pivots are skipped. The last survivor is found by a
// search back from the last point. In emission a survivor is read only once
// the previous read has reached the output register, as the point store has
// a single read port; removed points are skipped. s_axis_tready is low from
// the last beat until the set is cleared after the last survivor has entered
// the output register. Reset empties the store and returns merge_distance to
// 2560; a stalled receiver holds the output beat and emission simply waits.
// ----------------------------------------------------------------------------
module distance_threshold_point_thinning #(
    parameter int MAX_POINTS = dtpt_pkg::MAX_POINTS_DEF,
    parameter int COORD_BITS = dtpt_pkg::COORD_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,

    // Input points.
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // tdata from bit 0: pos_x, pos_y, pos_z, point_scalar, zero padding
    input  logic [((3*COORD_BITS + dtpt_pkg::SCALAR_W + 7) / 8) * 8 - 1:0] s_axis_tdata,
    input  logic                                s_axis_tlast,

    // Surviving points.
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // tdata from bit 0: keep_x, keep_y, keep_z, keep_scalar, zero padding
    output logic [((3*COORD_BITS + dtpt_pkg::SCALAR_W + 7) / 8) * 8 - 1:0] m_axis_tdata,
    output logic                                m_axis_tlast,
    // tuser: set_overflow
    output logic                                m_axis_tuser,

    // Configuration port.
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [dtpt_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [dtpt_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [dtpt_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready
);

    localparam int CB     = COORD_BITS;
    localparam int SW     = dtpt_pkg::SCALAR_W;
    localparam int DATA_W = ((3 * CB + SW + 7) / 8) * 8;
    localparam int IDX_W  = $clog2(MAX_POINTS);

    // The threshold register. The word address picks the register; the low
    // two address bits select a byte within the word and are ignored.
    logic [dtpt_pkg::DIST_W-1:0] dist_reg;
    logic                        cfg_hit;

    assign pready  = 1'b1;
    assign cfg_hit = (paddr[2] == dtpt_pkg::REG_IDX_MERGE_DISTANCE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dist_reg <= dtpt_pkg::DIST_RESET;
        end
        else if (psel && penable && pwrite && cfg_hit)
        begin
            dist_reg <= pwdata[dtpt_pkg::DIST_W-1:0];
        end
    end

    assign prdata = cfg_hit ? dtpt_pkg::APB_DATA_W'(dist_reg) : '0;

    // Controller and datapath.
    dtpt_pkg::cmd_t    cmd;
    dtpt_pkg::status_t status;
    logic [IDX_W-1:0]  rd_idx;
    logic [IDX_W-1:0]  wr_idx;

    logic signed [CB-1:0] keep_x, keep_y, keep_z;
    logic [SW-1:0]        keep_scalar;

    dtpt_ctrl #(
        .MAX_POINTS (MAX_POINTS)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_last  (s_axis_tlast),
        .in_ready (s_axis_tready),
        .cmd      (cmd),
        .status   (status),
        .rd_idx   (rd_idx),
        .wr_idx   (wr_idx)
    );

    dtpt_datapath #(
        .MAX_POINTS (MAX_POINTS),
        .COORD_BITS (COORD_BITS)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .rd_idx         (rd_idx),
        .wr_idx         (wr_idx),
        .merge_distance (dist_reg),
        .pos_x          (s_axis_tdata[CB-1:0]),
        .pos_y          (s_axis_tdata[2*CB-1:CB]),
        .pos_z          (s_axis_tdata[3*CB-1:2*CB]),
        .point_scalar   (s_axis_tdata[3*CB+SW-1:3*CB]),
        .out_valid      (m_axis_tvalid),
        .out_ready      (m_axis_tready),
        .keep_x         (keep_x),
        .keep_y         (keep_y),
        .keep_z         (keep_z),
        .keep_scalar    (keep_scalar),
        .final_survivor (m_axis_tlast),
        .set_overflow   (m_axis_tuser)
    );

    assign m_axis_tdata = DATA_W'({keep_scalar, keep_z, keep_y, keep_x});

endmodule

// File: design/dtpt_ram.sv
// ----------------------------------------------------------------------------
// dtpt_ram
// Generic single write port, single read port RAM with a registered read.
// ----------------------------------------------------------------------------
module dtpt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// File: design/dtpt_datapath.sv
// ----------------------------------------------------------------------------
// dtpt_datapath
// Point and scalar stores, pivot register, four-stage distance compare pipe,
// removal marks and the output register.
// ----------------------------------------------------------------------------
module dtpt_datapath #(
    parameter int MAX_POINTS = dtpt_pkg::MAX_POINTS_DEF,
    parameter int COORD_BITS = dtpt_pkg::COORD_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  dtpt_pkg::cmd_t                      cmd,
    output dtpt_pkg::status_t                   status,
    input  logic [$clog2(MAX_POINTS)-1:0]       rd_idx,
    input  logic [$clog2(MAX_POINTS)-1:0]       wr_idx,
    input  logic [dtpt_pkg::DIST_W-1:0]         merge_distance,
    input  logic signed [COORD_BITS-1:0]        pos_x,
    input  logic signed [COORD_BITS-1:0]        pos_y,
    input  logic signed [COORD_BITS-1:0]        pos_z,
    input  logic [dtpt_pkg::SCALAR_W-1:0]       point_scalar,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [COORD_BITS-1:0]        keep_x,
    output logic signed [COORD_BITS-1:0]        keep_y,
    output logic signed [COORD_BITS-1:0]        keep_z,
    output logic [dtpt_pkg::SCALAR_W-1:0]       keep_scalar,
    output logic                                final_survivor,
    output logic                                set_overflow
);

    localparam int IDX_W = $clog2(MAX_POINTS);
    localparam int CB    = COORD_BITS;
    localparam int DW    = dtpt_pkg::DIST_W;
    localparam int SQ_W  = 2 * CB;
    localparam int SUM_W = 2 * CB + 2;

    logic [3*CB-1:0]              wr_coord;
    logic [3*CB-1:0]              rd_coord;
    logic [dtpt_pkg::SCALAR_W-1:0] rd_scalar;

    assign wr_coord = {pos_z, pos_y, pos_x};

    dtpt_ram #(
        .WIDTH (3 * CB),
        .DEPTH (MAX_POINTS)
    ) u_coord_ram (
        .clk     (clk),
        .wr_en   (cmd.wr_en),
        .wr_addr (wr_idx),
        .wr_data (wr_coord),
        .rd_addr (rd_idx),
        .rd_data (rd_coord)
    );

    dtpt_ram #(
        .WIDTH (dtpt_pkg::SCALAR_W),
        .DEPTH (MAX_POINTS)
    ) u_scalar_ram (
        .clk     (clk),
        .wr_en   (cmd.wr_en),
        .wr_addr (wr_idx),
        .wr_data (point_scalar),
        .rd_addr (rd_idx),
        .rd_data (rd_scalar)
    );

    // Threshold and its square, fixed for the whole set.
    logic [DW-1:0]   thr_reg;
    logic [2*DW-1:0] thr_sq_reg;
    logic [3*CB-1:0] piv_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            thr_reg <= merge_distance;
        end
        if (cmd.square)
        begin
            thr_sq_reg <= thr_reg * thr_reg;
        end
        if (cmd.piv_load)
        begin
            piv_reg <= rd_coord;
        end
    end

    // Compare pipe: read, absolute differences, squares, sum, compare.
    logic             v0_reg, v1_reg, v2_reg, v3_reg;
    logic [IDX_W-1:0] j0_reg, j1_reg, j2_reg, j3_reg;
    logic [CB-1:0]    d1_reg [3];
    logic [SQ_W-1:0]  sq2_reg [3];
    logic [SUM_W-1:0] sum3_reg;
    logic             over1_reg, over2_reg, over3_reg;

    logic [CB-1:0]    d1_next [3];
    logic             over1_next;
    logic [SUM_W-1:0] sum3_next;
    logic             hit;

    always_comb
    begin
        logic [CB:0] diff;
        logic [CB:0] mag;
        over1_next = 1'b0;
        for (int k = 0; k < 3; k++)
        begin
            diff = {rd_coord[k*CB + CB - 1], rd_coord[k*CB +: CB]}
                 - {piv_reg[k*CB + CB - 1], piv_reg[k*CB +: CB]};
            mag  = diff[CB] ? (~diff + 1'b1) : diff;
            d1_next[k] = mag[CB-1:0];
            if ({{DW{1'b0}}, d1_next[k]} > {{CB{1'b0}}, thr_reg})
            begin
                over1_next = 1'b1;
            end
        end
    end

    assign sum3_next = SUM_W'(sq2_reg[0]) + SUM_W'(sq2_reg[1]) + SUM_W'(sq2_reg[2]);
    assign hit = v3_reg && !over3_reg
              && ({{(2*DW){1'b0}}, sum3_reg} <= {{SUM_W{1'b0}}, thr_sq_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v0_reg <= cmd.cmp_issue;
            v1_reg <= v0_reg;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        j0_reg    <= rd_idx;
        j1_reg    <= j0_reg;
        j2_reg    <= j1_reg;
        j3_reg    <= j2_reg;
        over1_reg <= over1_next;
        over2_reg <= over1_reg;
        over3_reg <= over2_reg;
        for (int k = 0; k < 3; k++)
        begin
            d1_reg[k]  <= d1_next[k];
            sq2_reg[k] <= d1_reg[k] * d1_reg[k];
        end
        sum3_reg <= sum3_next;
    end

    // Removal marks, cleared at reset and at the end of each set.
    logic [MAX_POINTS-1:0] mark_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mark_reg <= '0;
        end
        else if (cmd.clear)
        begin
            mark_reg <= '0;
        end
        else if (hit)
        begin
            mark_reg[j3_reg] <= 1'b1;
        end
    end

    // Output register.
    logic epend_reg, efin_reg, eovf_reg;
    logic out_valid_reg;
    logic signed [CB-1:0] out_x_reg, out_y_reg, out_z_reg;
    logic [dtpt_pkg::SCALAR_W-1:0] out_scalar_reg;
    logic out_fin_reg, out_ovf_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            epend_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            epend_reg <= cmd.emit_issue;
            if (epend_reg)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit_issue)
        begin
            efin_reg <= cmd.emit_final;
            eovf_reg <= cmd.overflow;
        end
        if (epend_reg)
        begin
            out_x_reg      <= rd_coord[CB-1:0];
            out_y_reg      <= rd_coord[2*CB-1:CB];
            out_z_reg      <= rd_coord[3*CB-1:2*CB];
            out_scalar_reg <= rd_scalar;
            out_fin_reg    <= efin_reg;
            out_ovf_reg    <= eovf_reg;
        end
    end

    assign out_valid      = out_valid_reg;
    assign keep_x         = out_x_reg;
    assign keep_y         = out_y_reg;
    assign keep_z         = out_z_reg;
    assign keep_scalar    = out_scalar_reg;
    assign final_survivor = out_fin_reg;
    assign set_overflow   = out_ovf_reg;

    assign status.removed   = mark_reg[rd_idx];
    assign status.pipe_busy = v0_reg | v1_reg | v2_reg | v3_reg;
    assign status.emit_ok   = !epend_reg && (!out_valid_reg || out_ready);
    assign status.emit_pend = epend_reg;

`ifndef ASSERT_OFF
    // The first point of a set is never removed by a later one.
    assert property (@(posedge clk) disable iff (!rst_n) !mark_reg[0])
        else $error("point 0 marked as removed");

    // A point is only sent to the output register when it has room.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit_issue |=> !out_valid_reg || $past(out_ready))
        else $error("output read issued while output register full");

    // A pivot is only latched once every compare of the previous one is done.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.piv_load |-> !v1_reg && !v2_reg && !v3_reg)
        else $error("pivot changed with compares in flight");
`endif

endmodule

// File: design/dtpt_ctrl.sv
// ----------------------------------------------------------------------------
// dtpt_ctrl
// Controller: loads a set, walks pivots and sweeps later points, finds the
// last survivor and sequences the emission.
// ----------------------------------------------------------------------------
module dtpt_ctrl #(
    parameter int MAX_POINTS = dtpt_pkg::MAX_POINTS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    input  logic                                in_last,
    output logic                                in_ready,
    output dtpt_pkg::cmd_t                      cmd,
    input  dtpt_pkg::status_t                   status,
    output logic [$clog2(MAX_POINTS)-1:0]       rd_idx,
    output logic [$clog2(MAX_POINTS)-1:0]       wr_idx
);

    localparam int IDX_W = $clog2(MAX_POINTS);
    localparam int CNT_W = $clog2(MAX_POINTS + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_POINTS);

    dtpt_pkg::state_t state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [CNT_W-1:0] i_reg, i_next;
    logic [CNT_W-1:0] j_reg, j_next;
    logic [IDX_W-1:0] last_reg, last_next;
    logic             ovf_reg, ovf_next;

    logic in_fire;
    logic store_full;
    logic pivot_end;
    logic sweep_end;
    logic emit_end;

    assign in_fire    = in_valid && (state_reg == dtpt_pkg::ST_LOAD);
    assign store_full = (cnt_reg == CNT_MAX);
    assign pivot_end  = ((i_reg + 1'b1) >= cnt_reg);
    assign sweep_end  = ((j_reg + 1'b1) == cnt_reg);
    assign emit_end   = (i_reg == cnt_reg);

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            dtpt_pkg::ST_LOAD:
            begin
                if (in_fire && in_last)
                begin
                    state_next = dtpt_pkg::ST_SQUARE;
                end
            end
            dtpt_pkg::ST_SQUARE:
            begin
                state_next = dtpt_pkg::ST_PIVOT;
            end
            dtpt_pkg::ST_PIVOT:
            begin
                if (pivot_end)
                begin
                    state_next = dtpt_pkg::ST_FINDLAST;
                end
                else if (!status.removed)
                begin
                    state_next = dtpt_pkg::ST_PIVLD;
                end
            end
            dtpt_pkg::ST_PIVLD:
            begin
                state_next = dtpt_pkg::ST_SWEEP;
            end
            dtpt_pkg::ST_SWEEP:
            begin
                if (sweep_end)
                begin
                    state_next = dtpt_pkg::ST_DRAIN;
                end
            end
            dtpt_pkg::ST_DRAIN:
            begin
                if (!status.pipe_busy)
                begin
                    state_next = dtpt_pkg::ST_PIVOT;
                end
            end
            dtpt_pkg::ST_FINDLAST:
            begin
                if (!status.removed)
                begin
                    state_next = dtpt_pkg::ST_EMIT;
                end
            end
            dtpt_pkg::ST_EMIT:
            begin
                if (emit_end && !status.emit_pend)
                begin
                    state_next = dtpt_pkg::ST_LOAD;
                end
            end
            default:
            begin
                state_next = dtpt_pkg::ST_LOAD;
            end
        endcase
    end

    // Commands to the datapath.
    always_comb
    begin
        cmd          = '0;
        cmd.overflow = ovf_reg;
        in_ready     = 1'b0;
        rd_idx       = i_reg[IDX_W-1:0];
        case (state_reg)
            dtpt_pkg::ST_LOAD:
            begin
                in_ready  = 1'b1;
                cmd.wr_en = in_fire && !store_full;
                cmd.start = in_fire && in_last;
            end
            dtpt_pkg::ST_SQUARE:
            begin
                cmd.square = 1'b1;
            end
            dtpt_pkg::ST_PIVOT:
            begin
                rd_idx = i_reg[IDX_W-1:0];
            end
            dtpt_pkg::ST_PIVLD:
            begin
                cmd.piv_load = 1'b1;
            end
            dtpt_pkg::ST_SWEEP:
            begin
                rd_idx        = j_reg[IDX_W-1:0];
                cmd.cmp_issue = 1'b1;
            end
            dtpt_pkg::ST_DRAIN:
            begin
                rd_idx = i_reg[IDX_W-1:0];
            end
            dtpt_pkg::ST_FINDLAST:
            begin
                rd_idx = i_reg[IDX_W-1:0];
            end
            dtpt_pkg::ST_EMIT:
            begin
                rd_idx = i_reg[IDX_W-1:0];
                if (emit_end)
                begin
                    cmd.clear = !status.emit_pend;
                end
                else if (!status.removed && status.emit_ok)
                begin
                    cmd.emit_issue = 1'b1;
                    cmd.emit_final = (i_reg[IDX_W-1:0] == last_reg);
                end
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    assign wr_idx = cnt_reg[IDX_W-1:0];

    // Counters and flags.
    always_comb
    begin
        cnt_next  = cnt_reg;
        i_next    = i_reg;
        j_next    = j_reg;
        last_next = last_reg;
        ovf_next  = ovf_reg;
        case (state_reg)
            dtpt_pkg::ST_LOAD:
            begin
                if (in_fire)
                begin
                    if (store_full)
                    begin
                        ovf_next = 1'b1;
                    end
                    else
                    begin
                        cnt_next = cnt_reg + 1'b1;
                    end
                end
                i_next = '0;
            end
            dtpt_pkg::ST_SQUARE:
            begin
                i_next = '0;
            end
            dtpt_pkg::ST_PIVOT:
            begin
                if (pivot_end)
                begin
                    i_next = cnt_reg - 1'b1;
                end
                else if (status.removed)
                begin
                    i_next = i_reg + 1'b1;
                end
                else
                begin
                    j_next = i_reg + 1'b1;
                end
            end
            dtpt_pkg::ST_SWEEP:
            begin
                j_next = j_reg + 1'b1;
            end
            dtpt_pkg::ST_DRAIN:
            begin
                if (!status.pipe_busy)
                begin
                    i_next = i_reg + 1'b1;
                end
            end
            dtpt_pkg::ST_FINDLAST:
            begin
                if (status.removed)
                begin
                    i_next = i_reg - 1'b1;
                end
                else
                begin
                    last_next = i_reg[IDX_W-1:0];
                    i_next    = '0;
                end
            end
            dtpt_pkg::ST_EMIT:
            begin
                if (emit_end)
                begin
                    if (!status.emit_pend)
                    begin
                        cnt_next = '0;
                        ovf_next = 1'b0;
                    end
                end
                else if (status.removed || status.emit_ok)
                begin
                    i_next = i_reg + 1'b1;
                end
            end
            default:
            begin
                i_next = i_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= dtpt_pkg::ST_LOAD;
            cnt_reg   <= '0;
            i_reg     <= '0;
            j_reg     <= '0;
            last_reg  <= '0;
            ovf_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            last_reg  <= last_next;
            ovf_reg   <= ovf_next;
        end
    end

`ifndef ASSERT_OFF
    // The fill count never passes the store size.
    assert property (@(posedge clk) disable iff (!rst_n) cnt_reg <= CNT_MAX)
        else $error("fill count beyond store size");

    // A set is only released once its last survivor has been handed over.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.clear |-> emit_end && !status.emit_pend && $past(cmd.emit_final || cmd.clear
        || status.removed || !status.emit_ok || state_reg == dtpt_pkg::ST_EMIT))
        else $error("set cleared before emission finished");
`endif

endmodule
